// ----- rtl/lru_key_tracker_core_defines.svh -----
// Assertion macros shared by the RTL of the LRU key tracker.
`ifndef LRU_KEY_TRACKER_CORE_DEFINES_SVH
`define LRU_KEY_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LKT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lkt_pkg.sv -----
// ----------------------------------------------------------------------------
// lkt_pkg
// Shared types for the LRU key tracker recency chain.
// ----------------------------------------------------------------------------
package lkt_pkg;

    // Broadcast command from the core to every chain cell.
    typedef struct packed {
        logic accept; // a reference transaction is taken this cycle
        logic miss;   // no cell matched the key
    } t_cell_cmd;

endpackage

// ----- rtl/lkt_cell.sv -----
// ----------------------------------------------------------------------------
// lkt_cell
// One slot of the recency chain: holds a tag and valid bit, compares the
// reference key, and loads its left neighbor's contents when the chain shifts.
// ----------------------------------------------------------------------------
module lkt_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lkt_pkg::t_cell_cmd    i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic                  i_prev_valid,
    input  logic [KEY_BITS-1:0]   i_prev_tag,
    input  logic                  i_match_right,
    output logic                  o_valid,
    output logic [KEY_BITS-1:0]   o_tag,
    output logic                  o_match,
    output logic                  o_match_chain
);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_tag;
    logic                w_load;

    assign o_match       = r_valid && (r_tag == i_key);
    // true if this cell or any older cell holds the key
    assign o_match_chain = o_match || i_match_right;
    // shift on a miss, or on a hit at or beyond this position
    assign w_load        = i_cmd.accept && (i_cmd.miss || o_match_chain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tag <= i_prev_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;

endmodule

// ----- rtl/lru_key_tracker_core.sv -----
// ----------------------------------------------------------------------------
// lru_key_tracker_core
// Fully associative LRU tracker of key tags built as a recency-ordered chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one key reference per
//   transaction. Output channel (o_out_valid / i_out_stall) returns one result
//   per reference: hit, evict_valid and the evicted key (zero if none).
//   Cells are kept in recency order, cell 0 most recent. A reference compares
//   against all cells at once; on a hit the cells in front of the matching one
//   shift back by one and the key enters cell 0; on a miss the whole chain
//   shifts and the last cell, if valid, is evicted.
//   Output: result is registered, valid in the cycle after the input transaction.
//   Throughput: one reference per cycle unless a stalled result holds the input;
//   the compare is combinational and the chain shifts as the reference is taken.
//   Stall: while a result waits under i_out_stall, o_in_stall is high and no
//   reference is taken; the result holds until it is taken.
//   Reset: all valid bits clear at once, the output register empties; the
//   block accepts a reference as soon as reset is released.
// ----------------------------------------------------------------------------
`include "lru_key_tracker_core_defines.svh"

module lru_key_tracker_core #(
    parameter int NUM_ENTRIES = 4,
    parameter int KEY_BITS    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KEY_BITS-1:0] i_ref_key,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_hit,
    output logic                o_evict_valid,
    output logic [KEY_BITS-1:0] o_evict_key
);

    logic [NUM_ENTRIES-1:0] w_valid;
    logic [KEY_BITS-1:0]    w_tag [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] w_match;
    logic [NUM_ENTRIES-1:0] w_match_chain;
    logic                   w_accept;
    logic                   w_miss;
    lkt_pkg::t_cell_cmd     w_cmd;

    logic                r_out_valid;
    logic                r_hit;
    logic                r_evict_valid;
    logic [KEY_BITS-1:0] r_evict_key;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_miss     = !w_match_chain[0];

    assign w_cmd.accept = w_accept;
    assign w_cmd.miss   = w_miss;

    genvar g;
    generate
        for (g = 0; g < NUM_ENTRIES; g++) begin : g_cell
            logic                w_prev_valid;
            logic [KEY_BITS-1:0] w_prev_tag;
            logic                w_match_right;

            if (g == 0) begin : g_head
                assign w_prev_valid = 1'b1;
                assign w_prev_tag   = i_ref_key;
            end else begin : g_body
                assign w_prev_valid = w_valid[g-1];
                assign w_prev_tag   = w_tag[g-1];
            end

            if (g == NUM_ENTRIES-1) begin : g_tail
                assign w_match_right = 1'b0;
            end else begin : g_inner
                assign w_match_right = w_match_chain[g+1];
            end

            lkt_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (w_cmd),
                .i_key         (i_ref_key),
                .i_prev_valid  (w_prev_valid),
                .i_prev_tag    (w_prev_tag),
                .i_match_right (w_match_right),
                .o_valid       (w_valid[g]),
                .o_tag         (w_tag[g]),
                .o_match       (w_match[g]),
                .o_match_chain (w_match_chain[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // the oldest cell falls off the chain on a miss
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit         <= !w_miss;
            r_evict_valid <= w_miss && w_valid[NUM_ENTRIES-1];
            r_evict_key   <= (w_miss && w_valid[NUM_ENTRIES-1]) ?
                             w_tag[NUM_ENTRIES-1] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_evict_valid = r_evict_valid;
    assign o_evict_key   = r_evict_key;

    `LKT_ASSERT_IMPL(a_match_unique, i_clk, i_rst_n, 1'b1, $onehot0(w_match), "key in two cells")
    `LKT_ASSERT_IMPL(a_valid_packed, i_clk, i_rst_n, 1'b1,
        (w_valid & ~{w_valid[NUM_ENTRIES-2:0], 1'b1}) == '0, "valid cells not packed")
    `LKT_ASSERT_IMPL(a_hit_no_evict, i_clk, i_rst_n, r_out_valid,
        !(r_hit && r_evict_valid), "hit with eviction")
    `LKT_ASSERT_IMPL(a_evict_key_zero, i_clk, i_rst_n, r_out_valid && !r_evict_valid,
        r_evict_key == '0, "evict key not zero")
    `LKT_ASSERT_NEXT(a_head_loaded, i_clk, i_rst_n, w_accept,
        w_valid[0] && (w_tag[0] == $past(i_ref_key)), "key not at head")

endmodule
